// ----- sv/lmsse_pkg.sv -----
// Shared types and constants for the linear model squared-error accumulator.
// No dependencies; used by lmsse_ctrl, lmsse_dpath and the top level.
package lmsse_pkg;

    localparam int DATA_W      = 16;              // Q8.8 field width
    localparam int Q_SHIFT     = 8;
    localparam int MAX_FEAT    = 4;               // feature ports on the block
    localparam int FEAT_IDX_W  = 2;               // index into MAX_FEAT entries
    localparam int PROD_W      = 2 * DATA_W;      // Q16.16 product
    localparam int TERM_W      = PROD_W - Q_SHIFT; // product after the shift
    localparam int PRED_W      = TERM_W + 3;      // sum of four terms plus intercept
    localparam int RES_W       = PRED_W + 1;      // target minus prediction
    localparam int SQ_W        = 2 * RES_W;       // squared residual
    localparam int SSE_W       = 63;
    localparam int CFG_IDX_W   = 3;

    localparam logic [SSE_W-1:0] SSE_MAX = {SSE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_RESID,
        ST_SQUARE,
        ST_ACCUM
    } state_t;

    typedef struct packed {
        logic                  load;    // capture the item, seed prediction
        logic                  mac;     // add one coefficient-feature term
        logic [FEAT_IDX_W-1:0] idx;     // feature of this term
        logic                  resid;   // form the residual magnitude
        logic                  square;  // register the square
        logic                  accum;   // add to the total, emit on last row
    } dp_cmd_t;

    typedef struct packed {
        logic last_row;  // captured item is the last of its data set
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

// ----- sv/lmsse_ctrl.sv -----
// Sequencer for the squared-error accumulator: walks one item through
// the term, residual, square and accumulate steps. Uses lmsse_pkg.
module lmsse_ctrl #(
    parameter int NUM_FEATURES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lmsse_pkg::dp_status_t status,
    output lmsse_pkg::dp_cmd_t    cmd
);

    localparam logic [lmsse_pkg::FEAT_IDX_W-1:0] LAST_IDX =
        lmsse_pkg::FEAT_IDX_W'(NUM_FEATURES - 1);

    lmsse_pkg::state_t                 state_reg, state_next;
    logic [lmsse_pkg::FEAT_IDX_W-1:0]  idx_reg, idx_next;
    logic                              accum_go;

    assign accum_go = !status.last_row || status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmsse_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            lmsse_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                    state_next = lmsse_pkg::ST_MAC;
            end
            lmsse_pkg::ST_MAC:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = lmsse_pkg::ST_RESID;
                else
                    idx_next = idx_reg + 1'b1;
            end
            lmsse_pkg::ST_RESID:  state_next = lmsse_pkg::ST_SQUARE;
            lmsse_pkg::ST_SQUARE: state_next = lmsse_pkg::ST_ACCUM;
            lmsse_pkg::ST_ACCUM:
            begin
                // on a last row, hold here while a previous total still waits at the output
                if (accum_go)
                    state_next = lmsse_pkg::ST_IDLE;
            end
            default: state_next = lmsse_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.idx  = idx_reg;
        in_stall = 1'b1;
        case (state_reg)
            lmsse_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            lmsse_pkg::ST_MAC:    cmd.mac    = 1'b1;
            lmsse_pkg::ST_RESID:  cmd.resid  = 1'b1;
            lmsse_pkg::ST_SQUARE: cmd.square = 1'b1;
            lmsse_pkg::ST_ACCUM:  cmd.accum  = accum_go;
            default:              in_stall   = 1'b1;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmsse_pkg::ST_IDLE && in_valid) |=> state_reg == lmsse_pkg::ST_MAC)
        else $error("accepted item did not start the term loop");

    a_accum_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |=> state_reg == lmsse_pkg::ST_IDLE)
        else $error("accumulate step did not return to idle");

    a_mac_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac |-> idx_reg <= LAST_IDX)
        else $error("term index ran past the feature count");
`endif

endmodule

// ----- sv/lmsse_dpath.sv -----
// Datapath: configuration registers, item capture, shared term multiplier,
// residual, squarer, saturating total and output register. Uses lmsse_pkg.
module lmsse_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lmsse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lmsse_pkg::DATA_W-1:0]           cfg_data,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_zero,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_one,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_two,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_three,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    target,
    input  logic                                   last_row,
    input  lmsse_pkg::dp_cmd_t                     cmd,
    output lmsse_pkg::dp_status_t                  status,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lmsse_pkg::SSE_W-1:0]            sum_sq_error,
    output logic                                   overflowed
);

    localparam int DW = lmsse_pkg::DATA_W;

    logic signed [DW-1:0]                    coef_reg [lmsse_pkg::MAX_FEAT];
    logic signed [DW-1:0]                    intercept_reg;
    logic signed [DW-1:0]                    feat_reg [lmsse_pkg::MAX_FEAT];
    logic signed [DW-1:0]                    target_reg;
    logic                                    last_reg;
    logic signed [lmsse_pkg::PRED_W-1:0]     pred_reg;
    logic [lmsse_pkg::RES_W-1:0]             mag_reg;
    logic [lmsse_pkg::SQ_W-1:0]              sq_reg;
    logic [lmsse_pkg::SSE_W-1:0]             total_reg;
    logic                                    sat_reg;
    logic [lmsse_pkg::SSE_W-1:0]             out_total_reg;
    logic                                    out_flag_reg;
    logic                                    out_valid_reg;

    logic signed [lmsse_pkg::PROD_W-1:0]     product;
    logic signed [lmsse_pkg::TERM_W-1:0]     term;
    logic signed [lmsse_pkg::RES_W-1:0]      diff;
    logic [lmsse_pkg::SSE_W:0]               sum_wide;
    logic                                    sat_now;
    logic [lmsse_pkg::SSE_W-1:0]             total_next;
    logic                                    sat_next;
    logic                                    emit;
    logic                                    out_taken;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmsse_pkg::MAX_FEAT; i++)
                coef_reg[i] <= '0;
            intercept_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index < lmsse_pkg::REG_INTERCEPT)
                coef_reg[cfg_index[lmsse_pkg::FEAT_IDX_W-1:0]] <= cfg_data;
            else if (cfg_index == lmsse_pkg::REG_INTERCEPT)
                intercept_reg <= cfg_data;
        end
    end

    // one term per cycle: floor shift of the Q16.16 product to Q16.8
    assign product = coef_reg[cmd.idx] * feat_reg[cmd.idx];
    assign term    = product[lmsse_pkg::PROD_W-1:lmsse_pkg::Q_SHIFT];

    assign diff = lmsse_pkg::RES_W'(target_reg) - lmsse_pkg::RES_W'(pred_reg);

    assign sum_wide   = {1'b0, total_reg} + (lmsse_pkg::SSE_W + 1)'(sq_reg);
    assign sat_now    = sum_wide > {1'b0, lmsse_pkg::SSE_MAX};
    assign total_next = sat_now ? lmsse_pkg::SSE_MAX : sum_wide[lmsse_pkg::SSE_W-1:0];
    assign sat_next   = sat_reg | sat_now;

    assign emit      = cmd.accum && last_reg;
    assign out_taken = out_valid_reg && !out_stall;

    // item capture and arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            feat_reg[0] <= feature_zero;
            feat_reg[1] <= feature_one;
            feat_reg[2] <= feature_two;
            feat_reg[3] <= feature_three;
            target_reg  <= target;
            last_reg    <= last_row;
            pred_reg    <= lmsse_pkg::PRED_W'(intercept_reg);
        end
        else if (cmd.mac)
            pred_reg <= pred_reg + lmsse_pkg::PRED_W'(term);
        if (cmd.resid)
            mag_reg <= diff[lmsse_pkg::RES_W-1] ? lmsse_pkg::RES_W'(-diff)
                                                : lmsse_pkg::RES_W'(diff);
        if (cmd.square)
            sq_reg <= mag_reg * mag_reg;
        if (emit)
        begin
            out_total_reg <= total_next;
            out_flag_reg  <= sat_next;
        end
    end

    // running total; clear after a data set is emitted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                total_reg <= last_reg ? '0 : total_next;
                sat_reg   <= last_reg ? 1'b0 : sat_next;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_taken)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.last_row = last_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign sum_sq_error = out_total_reg;
    assign overflowed   = out_flag_reg;

`ifndef NO_ASSERTIONS
    a_flag_means_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flag_reg) |-> out_total_reg == lmsse_pkg::SSE_MAX)
        else $error("overflow flag set on a total below full scale");

    a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> total_reg == lmsse_pkg::SSE_MAX)
        else $error("saturated total left full scale");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a waiting total");
`endif

endmodule

// ----- sv/linear_model_sse_accumulator_top.sv -----
// Top level of the linear model squared-error accumulator.
// Depends on lmsse_pkg, lmsse_ctrl and lmsse_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall): one item is a data row of four
//   signed Q8.8 features, a Q8.8 target and a last_row mark. Only the first
//   NUM_FEATURES features take part in the prediction.
//   Output channel (out_valid / out_stall): one item per data set, sent
//   after the row marked last: the 63-bit saturated sum of squared
//   residuals (Q47.16) and the overflowed flag. Total and flag then clear.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0..3 coefficients, 4 intercept); other indexes are dropped. Write
//   only while the block is idle.
// Rows: one row at a time; the input stalls until it has passed the accept
//   step, one shared 16x16 term multiply per feature, residual, square, accumulate.
// Result: out_valid is registered and rises after the last row's accumulate
//   step, which follows its term, residual and square steps.
// Stall: the total waits in an output register, so the next data set can
//   start at once; only a second last row waits in its accumulate step
//   until the held total is taken.
// Reset: coefficients, intercept, total and flag clear; no output pending.
module linear_model_sse_accumulator_top #(
    parameter int NUM_FEATURES = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic [lmsse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lmsse_pkg::DATA_W-1:0]           cfg_data,
    // row input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_zero,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_one,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_two,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    feature_three,
    input  logic signed [lmsse_pkg::DATA_W-1:0]    target,
    input  logic                                   last_row,
    // result output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lmsse_pkg::SSE_W-1:0]            sum_sq_error,
    output logic                                   overflowed
);

    // command and status between the sequencer and the datapath
    lmsse_pkg::dp_cmd_t    cmd;
    lmsse_pkg::dp_status_t status;

    lmsse_ctrl #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lmsse_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .feature_zero  (feature_zero),
        .feature_one   (feature_one),
        .feature_two   (feature_two),
        .feature_three (feature_three),
        .target        (target),
        .last_row      (last_row),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sum_sq_error  (sum_sq_error),
        .overflowed    (overflowed)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a second row while one is at work");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for linear_model_sse_accumulator_top: streams data rows and register writes,
// predicts each data set's saturated squared-error total and checks every result item.
// Depends on lmsse_pkg and the block's RTL; reads no files.
module testbench;

    localparam int     N_FEAT      = 4;
    localparam int     LATENCY     = N_FEAT + 3;   // last row accepted -> out_valid
    localparam int     HOLD_LEN    = 400;          // long receiver hold-off, in cycles
    localparam int     BIG_ROWS    = 40;           // maximal squares in one long set
    localparam longint CYCLE_LIMIT = 2_000_000;

    // One data row as the sender offers it.
    typedef struct packed {
        logic [3:0][lmsse_pkg::DATA_W-1:0] feat;
        logic [lmsse_pkg::DATA_W-1:0]      tgt;
        logic                              last;
    } row_t;

    // One data-set total as the block should report it.
    typedef struct packed {
        logic [lmsse_pkg::SSE_W-1:0] sse;
        logic                        ovf;
    } total_t;

    // ------------------------------------------------------------------
    // Block ports; every input is known from time zero.
    // ------------------------------------------------------------------
    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [lmsse_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [lmsse_pkg::DATA_W-1:0]    cfg_data      = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic [lmsse_pkg::DATA_W-1:0]    feature_zero  = '0;
    logic [lmsse_pkg::DATA_W-1:0]    feature_one   = '0;
    logic [lmsse_pkg::DATA_W-1:0]    feature_two   = '0;
    logic [lmsse_pkg::DATA_W-1:0]    feature_three = '0;
    logic [lmsse_pkg::DATA_W-1:0]    target        = '0;
    logic                            last_row      = 1'b0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic [lmsse_pkg::SSE_W-1:0]     sum_sq_error;
    logic                            overflowed;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the running total.
    // ------------------------------------------------------------------
    logic signed [lmsse_pkg::DATA_W-1:0] coef_q [N_FEAT];
    logic signed [lmsse_pkg::DATA_W-1:0] icept_q;
    logic [lmsse_pkg::SSE_W-1:0]         sse_acc;
    logic                                sat_acc;
    total_t                              totals_due [$];   // totals predicted, not yet seen

    // Run bookkeeping.
    int     errors         = 0;
    int     rows_sent      = 0;
    int     totals_checked = 0;
    int     sat_sets       = 0;
    int     settings       = 0;
    longint cycles         = 0;

    // Idling knobs, in percent: per row for the sender, per cycle for the receiver; zero turns a side's idling off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int burst_left    = 0;

    linear_model_sse_accumulator_top #(
        .NUM_FEATURES (N_FEAT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .feature_zero  (feature_zero),
        .feature_one   (feature_one),
        .feature_two   (feature_two),
        .feature_three (feature_three),
        .target        (target),
        .last_row      (last_row),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sum_sq_error  (sum_sq_error),
        .overflowed    (overflowed)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Square of (target - prediction) for one row, held exactly in 64 bits.
    // Each product is Q16.16; the arithmetic shift floors it to Q16.8.
    function automatic logic [63:0] residual_square(row_t r);
        logic signed [63:0] pred;
        logic signed [63:0] prod;
        logic signed [63:0] resid;
        pred = icept_q;
        for (int i = 0; i < N_FEAT; i++)
        begin
            prod = coef_q[i] * $signed(r.feat[i]);
            pred = pred + (prod >>> lmsse_pkg::Q_SHIFT);
        end
        resid = $signed(r.tgt) - pred;
        if (resid < 0)
            resid = -resid;
        return resid * resid;
    endfunction

    // Fold one accepted row into the running total; a last row closes the
    // data set, queues its total and clears total and flag.
    function automatic void absorb_row(row_t r);
        logic [63:0] sq;
        total_t      tot;
        sq = residual_square(r);
        if (sq > 64'(lmsse_pkg::SSE_MAX) - 64'(sse_acc))
        begin
            sse_acc = lmsse_pkg::SSE_MAX;
            sat_acc = 1'b1;
        end
        else
        begin
            sse_acc = sse_acc + sq[lmsse_pkg::SSE_W-1:0];
        end
        if (r.last)
        begin
            tot.sse = sse_acc;
            tot.ovf = sat_acc;
            totals_due.insert(totals_due.size(), tot);
            if (sat_acc)
                sat_sets++;
            sse_acc = '0;
            sat_acc = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: check each accepted total, then pick next cycle's stall.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        total_t due;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            // out_valid and out_stall read here still hold their pre-edge values
            if (out_valid && !out_stall)
            begin
                if (totals_due.size() == 0)
                begin
                    $error("total with none pending: sum_sq_error=%0d overflowed=%0b",
                           sum_sq_error, overflowed);
                    errors++;
                end
                else
                begin
                    due = totals_due.pop_front();
                    totals_checked++;
                    if (sum_sq_error !== due.sse)
                    begin
                        $error("sum_sq_error: expected %0d, got %0d", due.sse, sum_sq_error);
                        errors++;
                    end
                    if (overflowed !== due.ovf)
                    begin
                        $error("overflowed: expected %0b, got %0b", due.ovf, overflowed);
                        errors++;
                    end
                end
            end

            // A long hold-off wins over the short random bursts.
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                burst_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side helpers
    // ------------------------------------------------------------------

    function automatic row_t mk_row(input logic [lmsse_pkg::DATA_W-1:0] f0, f1, f2, f3, t,
                                    input logic last);
        row_t r;
        r.feat[0] = f0;
        r.feat[1] = f1;
        r.feat[2] = f2;
        r.feat[3] = f3;
        r.tgt     = t;
        r.last    = last;
        return r;
    endfunction

    // Random Q8.8 value, weighted toward the extremes and small magnitudes.
    function automatic logic [lmsse_pkg::DATA_W-1:0] pick_q88();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted; optionally idle first.
    task automatic send_row(input row_t r);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        feature_zero  <= r.feat[0];
        feature_one   <= r.feat[1];
        feature_two   <= r.feat[2];
        feature_three <= r.feat[3];
        target        <= r.tgt;
        last_row      <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_row(r);
        rows_sent++;
    endtask

    // Drop valid, wait for every pending total, then let the pipeline empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (totals_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lmsse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmsse_pkg::DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < lmsse_pkg::REG_INTERCEPT)
            coef_q[idx[lmsse_pkg::FEAT_IDX_W-1:0]] = val;
        else if (idx == lmsse_pkg::REG_INTERCEPT)
            icept_q = val;
    endtask

    // Write all five registers; call only with the block idle.
    task automatic load_model(input logic [lmsse_pkg::DATA_W-1:0] c0, c1, c2, c3, ic);
        write_reg(lmsse_pkg::REG_COEF_ZERO, c0);
        write_reg(lmsse_pkg::REG_COEF_ONE, c1);
        write_reg(lmsse_pkg::REG_COEF_TWO, c2);
        write_reg(lmsse_pkg::REG_COEF_THREE, c3);
        write_reg(lmsse_pkg::REG_INTERCEPT, ic);
        // a stray index past the intercept must leave every register alone
        write_reg(lmsse_pkg::CFG_IDX_W'($urandom_range(lmsse_pkg::REG_INTERCEPT + 1,
                                                       (1 << lmsse_pkg::CFG_IDX_W) - 1)),
                  16'($urandom));
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Data sets of random length and content, until about `rows` rows are sent.
    task automatic send_random_sets(input int rows);
        int len;
        int done;
        done = 0;
        while (done < rows)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_row(mk_row(pick_q88(), pick_q88(), pick_q88(), pick_q88(), pick_q88(),
                                k == len - 1));
            done += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With reset weights the prediction is zero, so each square is target^2.
    task automatic test_reset_values();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_row(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0));
        send_row(mk_row(16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h7FFF, 1'b0));
        send_row(mk_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 1'b1));
        // single-row data set
        send_row(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
        drain();
    endtask

    // Extreme weights and fields, rounding of negative products, one-row sets.
    task automatic test_directed();
        load_model(16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_row(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        // products of -1/65536 must floor to -1/256, not truncate to zero
        send_row(mk_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_row(mk_row(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_row(mk_row(16'hFFFF, 16'h0001, 16'h0001, 16'h0001, 16'h0000, 1'b0));
        send_row(mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_row(mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_row(mk_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b1));
        drain();

        load_model(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_row(mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
        send_row(mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_row(mk_row(16'h7FFF, 16'h8000, 16'h00FF, 16'hFF01, 16'h8000, 1'b1));
        drain();

        load_model(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_row(mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
        send_row(mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1));
        drain();
    endtask

    // Largest squares back to back in one long set, so the total runs far
    // above 32 bits; the sets after it must start again from zero.
    task automatic test_saturation();
        load_model(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_idle_pct = 0;
        recv_idle_pct = 20;
        for (int k = 0; k < BIG_ROWS; k++)
            send_row(mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_row(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_row(mk_row(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_row(mk_row(16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0200, 1'b1));
        drain();
    endtask

    // Hold the output off for a long stretch while rows with frequent last
    // marks keep coming, so the held total backs up into the input.
    task automatic test_backpressure();
        load_model(pick_q88(), pick_q88(), pick_q88(), pick_q88(), pick_q88());
        send_idle_pct = 10;
        hold_req      = 1'b1;
        for (int k = 0; k < 48; k++)
            send_row(mk_row(pick_q88(), pick_q88(), pick_q88(), pick_q88(), pick_q88(),
                            k % 3 == 2));
        drain();
    endtask

    // Random data sets across a range of register settings.
    task automatic test_random_sets();
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: load_model(16'h0000, 16'h0000, 16'h0000, 16'h0000, pick_q88());
                1: load_model(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                2: load_model(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
                3: load_model(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000);
                default: load_model(pick_q88(), pick_q88(), pick_q88(), pick_q88(),
                                    pick_q88());
            endcase
            // one phase runs with no idling on either side
            send_idle_pct = (p == 2) ? 0 : $urandom_range(10, 40);
            recv_idle_pct = (p == 2) ? 0 : $urandom_range(10, 40);
            send_random_sets(170);
            drain();
        end
    endtask

    // Closing stretch at full rate: no idling anywhere.
    task automatic test_full_rate_tail();
        load_model(pick_q88(), pick_q88(), pick_q88(), pick_q88(), pick_q88());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_sets(100);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < N_FEAT; i++)
            coef_q[i] = '0;
        icept_q = '0;
        sse_acc = '0;
        sat_acc = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_saturation();
        test_backpressure();
        test_random_sets();
        test_full_rate_tail();

        $display("Checked %0d data-set totals over %0d rows, %0d of them saturated.",
                 totals_checked, rows_sent, sat_sets);
        $display("Used %0d register settings, with long output hold-off and idle bursts.",
                 settings);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
